// ===== rtl/ncs_pkg.sv =====
// Shared types and constants for the nearest palette color search block.
`timescale 1ns / 1ps
package ncs_pkg;

  localparam int unsigned COLOR_W = 8;
  localparam int unsigned INDEX_W = 8;
  localparam int unsigned DIST_W  = 18;
  localparam int unsigned SQ_W    = 2 * COLOR_W;

  // Opcode carried on the input sideband.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Starting value of the running minimum; above any real distance.
  localparam logic [DIST_W-1:0] DIST_INIT = '1;

  typedef struct packed {
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
  } color_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic write_en;
    logic load_query;
    logic scan_clear;
    logic issue;
    logic load_out;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic at_last;
    logic pipe_busy;
  } dp_status_t;

endpackage

// ===== rtl/ncs_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module ncs_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/ncs_datapath.sv =====
// Datapath: palette memory, scan address counter, distance pipeline and running minimum.
`timescale 1ns / 1ps
module ncs_datapath
  import ncs_pkg::*;
#(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  ctrl_cmd_t          cmd,
  output dp_status_t         status,
  input  logic [INDEX_W-1:0] in_index,
  input  color_t             in_color,
  output logic [INDEX_W-1:0] best_index,
  output logic [DIST_W-1:0]  best_distance
);

  localparam int unsigned AW = $clog2(PALETTE_ENTRIES);

  logic [AW-1:0]     cnt;
  logic              wr_ok;
  logic [PALETTE_ENTRIES-1:0] vld;
  logic              vld_q;
  color_t            rd_color;
  color_t            query;
  logic              p1_valid;
  logic [AW-1:0]     p1_idx;
  logic              p2_valid;
  logic [AW-1:0]     p2_idx;
  logic [DIST_W-1:0] p2_dist;
  logic [AW-1:0]     run_idx;
  logic [DIST_W-1:0] run_dist;
  color_t            ent;
  logic [COLOR_W-1:0] dr, dg, db;
  logic [SQ_W-1:0]   sr, sg, sb;
  logic [DIST_W-1:0] sq_dist;

  // Writes beyond the palette are dropped.
  assign wr_ok = cmd.write_en &&
                 ({1'b0, in_index} < (INDEX_W + 1)'(PALETTE_ENTRIES));

  ncs_ram #(
    .WIDTH ($bits(color_t)),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk     (clk),
    .wr_en   (wr_ok),
    .wr_addr (in_index[AW-1:0]),
    .wr_data (in_color),
    .rd_en   (cmd.issue),
    .rd_addr (cnt),
    .rd_data (rd_color)
  );

  // One valid bit per entry; an entry never written reads as black.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_ok) begin
      vld[in_index[AW-1:0]] <= 1'b1;
    end
  end

  // Scan address counter and first pipeline stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      p1_valid <= 1'b0;
    end else begin
      if (cmd.scan_clear) begin
        cnt <= '0;
      end else if (cmd.issue) begin
        cnt <= cnt + 1'b1;
      end
      p1_valid <= cmd.issue;
    end
    if (cmd.issue) begin
      vld_q  <= vld[cnt];
      p1_idx <= cnt;
    end
  end

  // Latch the query color.
  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      query <= in_color;
    end
  end

  // Squared Euclidean distance of the entry just read.
  always_comb begin
    ent     = vld_q ? rd_color : '0;
    dr      = (query.red   > ent.red)   ? query.red   - ent.red   : ent.red   - query.red;
    dg      = (query.green > ent.green) ? query.green - ent.green : ent.green - query.green;
    db      = (query.blue  > ent.blue)  ? query.blue  - ent.blue  : ent.blue  - query.blue;
    sr      = dr * dr;
    sg      = dg * dg;
    sb      = db * db;
    sq_dist = DIST_W'(sr) + DIST_W'(sg) + DIST_W'(sb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else begin
      p2_valid <= p1_valid;
    end
    if (p1_valid) begin
      p2_dist <= sq_dist;
      p2_idx  <= p1_idx;
    end
  end

  // Running minimum; a strict compare keeps the lowest index on a tie.
  always_ff @(posedge clk) begin
    if (cmd.scan_clear) begin
      run_dist <= DIST_INIT;
      run_idx  <= '0;
    end else if (p2_valid && (p2_dist < run_dist)) begin
      run_dist <= p2_dist;
      run_idx  <= p2_idx;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      best_index    <= INDEX_W'(run_idx);
      best_distance <= run_dist;
    end
  end

  assign status.at_last   = (cnt == AW'(PALETTE_ENTRIES - 1));
  assign status.pipe_busy = p1_valid | p2_valid;

endmodule

// ===== rtl/ncs_ctrl.sv =====
// Controller: sequences palette writes, query scans and result hand-off.
`timescale 1ns / 1ps
module ncs_ctrl
  import ncs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_opcode,
  output logic       out_valid,
  input  logic       out_ready,
  output ctrl_cmd_t  cmd,
  input  dp_status_t status
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  state_t state;
  logic   in_fire;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Commands decoded from the current state and the input handshake.
  always_comb begin
    cmd            = '0;
    cmd.write_en   = in_fire && (in_opcode == OP_WRITE);
    cmd.load_query = in_fire && (in_opcode == OP_QUERY);
    cmd.scan_clear = in_fire && (in_opcode == OP_QUERY);
    cmd.issue      = (state == S_SCAN);
    cmd.load_out   = (state == S_FINISH) && out_free;
  end

  // State register and result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // A new result takes the output register as the old one leaves.
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire && (in_opcode == OP_QUERY)) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (status.at_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!status.pipe_busy) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/nearest_palette_color_search.sv =====
// Top level of the nearest palette color search block.
`timescale 1ns / 1ps
// Usage:
// The slave stream carries one command per beat. s_axis_tuser is the opcode:
// 0 writes the color in s_axis_tdata to entry entry_index, 1 queries the
// entry nearest to that color. A write beyond the palette is dropped.
// A write gives no result. A query scans all PALETTE_ENTRIES entries, one
// palette memory read per cycle, through a two-stage distance pipeline;
// its result then goes to the output register of the master stream, and
// the next beat is taken only after that.
// The result carries the lowest index at the minimum squared distance and
// that distance. It sits in an output register; the block takes a write
// while it waits, and a following query scans but holds its result until
// the receiver has taken the pending one.
// Reset clears every entry to black at once through per-entry valid bits,
// drops any scan in progress and any pending result.
module nearest_palette_color_search
  import ncs_pkg::*;
#(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] entry_index, [15:8] red, [23:16] green, [31:24] blue
  input  logic [31:0] s_axis_tdata,
  // [0] opcode
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] best_index, [25:8] best_distance, [31:26] zero
  output logic [31:0] m_axis_tdata
);

  ctrl_cmd_t          cmd;
  dp_status_t         status;
  color_t             in_color;
  logic [INDEX_W-1:0] best_index;
  logic [DIST_W-1:0]  best_distance;

  assign in_color.red   = s_axis_tdata[15:8];
  assign in_color.green = s_axis_tdata[23:16];
  assign in_color.blue  = s_axis_tdata[31:24];

  ncs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_opcode (s_axis_tuser),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .status    (status)
  );

  ncs_datapath #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .in_index      (s_axis_tdata[7:0]),
    .in_color      (in_color),
    .best_index    (best_index),
    .best_distance (best_distance)
  );

  assign m_axis_tdata = {6'd0, best_distance, best_index};

endmodule
